// ----- rtl/bpbc_pkg.sv -----
`default_nettype none

package bpbc_pkg;

   // Channel count and timer width of the controller.
   localparam int CHANNELS    = 8;
   localparam int TIMER_WIDTH = 16;
   localparam int MAX_RESULTS = 8;

   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Input commands.
   localparam logic [1:0] CMD_PIN    = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_LOCK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Actions on the long value; ACT_KEEP doubles as "none" for lock events.
   localparam logic [1:0] ACT_KEEP   = 2'd0;
   localparam logic [1:0] ACT_ZERO   = 2'd1;
   localparam logic [1:0] ACT_ONE    = 2'd2;
   localparam logic [1:0] ACT_TOGGLE = 2'd3;

   // Telegram kinds.
   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CFG_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_PRESS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_BLADE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_SHORT_LONG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_LOCK_ON    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_LOCK_OFF   = 3'd5;

   typedef struct packed {
      logic               long_short_mode;
      logic [1:0]         press_action;
      logic [TICKS_W-1:0] blade_ticks;
      logic [TICKS_W-1:0] short_long_ticks;
      logic [1:0]         lock_on_action;
      logic [1:0]         lock_off_action;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      long_short_mode:  1'b0,
      press_action:     ACT_TOGGLE,
      blade_ticks:      16'd50,
      short_long_ticks: 16'd40,
      lock_on_action:   ACT_KEEP,
      lock_off_action:  ACT_KEEP
   };

   typedef struct packed {
      logic                   running;
      logic [TIMER_WIDTH-1:0] count;
   } timer_type;

   // Request from the sequencer to the result buffer.
   typedef struct packed {
      logic       emit;
      logic       flush;
      logic       kind;
      logic [2:0] channel;
      logic       value;
   } res_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVENT,
      S_BLADE,
      S_SLONG,
      S_FLUSH
   } seq_state_type;

   function automatic logic act_value(input logic [1:0] action, input logic old);
      logic v;
      case (action)
         ACT_KEEP: v = old;
         ACT_ZERO: v = 1'b0;
         ACT_ONE:  v = 1'b1;
         default:  v = ~old;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bpbc_timer_unit.sv -----
`default_nettype none

module bpbc_timer_unit (
   input  bpbc_pkg::timer_type cur,
   output bpbc_pkg::timer_type nxt,
   output logic                expired
);
   import bpbc_pkg::*;

   logic [TIMER_WIDTH-1:0] dec;

   // Counts down to zero and stops there; reaching zero ends the run.
   assign dec = (cur.count != '0) ? cur.count - TIMER_WIDTH'(1) : '0;

   always_comb begin
      nxt     = cur;
      expired = 1'b0;
      if (cur.running) begin
         nxt.count = dec;
         if (dec == '0) begin
            nxt.running = 1'b0;
            expired     = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bpbc_rsp_buffer.sv -----
`default_nettype none

module bpbc_rsp_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  bpbc_pkg::res_cmd_type res_cmd,
   output logic                  res_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_telegram_kind,
   output logic [2:0]            rsp_out_channel,
   output logic                  rsp_out_value,
   output logic                  rsp_last
);
   import bpbc_pkg::*;

   // One result is held back until it is known whether another follows,
   // so that the last flag can be set on it.
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_kind_ff;
   logic [2:0] pend_chan_ff;
   logic       pend_value_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff;
   logic [2:0] out_chan_ff;
   logic       out_value_ff;
   logic       out_last_ff;
   logic       push_ok;
   logic       load_out;
   logic       take_cmd;

   assign push_ok   = ~out_valid_ff | ~rsp_stall;
   assign res_ready = ~pend_valid_ff | push_ok;
   assign take_cmd  = (res_cmd.emit | res_cmd.flush) & res_ready;
   assign load_out  = take_cmd & pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (take_cmd) begin
         pend_valid_in = res_cmd.emit;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_cmd && res_cmd.emit) begin
         pend_kind_ff  <= res_cmd.kind;
         pend_chan_ff  <= res_cmd.channel;
         pend_value_ff <= res_cmd.value;
      end
      if (load_out) begin
         out_kind_ff  <= pend_kind_ff;
         out_chan_ff  <= pend_chan_ff;
         out_value_ff <= pend_value_ff;
         out_last_ff  <= res_cmd.flush;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_telegram_kind = out_kind_ff;
   assign rsp_out_channel   = out_chan_ff;
   assign rsp_out_value     = out_value_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/bpbc_sequencer.sv -----
`default_nettype none

module bpbc_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [2:0]            req_channel,
   input  logic                  req_pin_level,
   input  logic                  req_lock_state,
   input  bpbc_pkg::cfg_type     cfg,
   input  logic                  res_ready,
   output bpbc_pkg::res_cmd_type res_cmd
);
   import bpbc_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [1:0]       cmd_ff;
   logic [2:0]       chan_ff;
   logic             pin_ff;
   logic             lock_ff;
   logic [CH_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic      long_ff  [CHANNELS];
   logic      long_in  [CHANNELS];
   logic      short_ff [CHANNELS];
   logic      short_in [CHANNELS];
   timer_type blade_ff [CHANNELS];
   timer_type blade_in [CHANNELS];
   timer_type slong_ff [CHANNELS];
   timer_type slong_in [CHANNELS];

   logic [CH_W-1:0] ev_idx;
   logic            ev_ok;
   logic            press_v;
   logic [1:0]      lock_act;
   logic            lock_v;
   logic            last_chan;
   logic            skip;
   timer_type       tu_cur;
   timer_type       tu_nxt;
   logic            tu_expired;
   timer_type       blade_load;
   timer_type       slong_load;

   assign ev_idx    = CH_W'(chan_ff);
   assign ev_ok     = 32'(chan_ff) < 32'(CHANNELS);
   assign press_v   = act_value(cfg.press_action, long_ff[ev_idx]);
   assign lock_act  = lock_ff ? cfg.lock_on_action : cfg.lock_off_action;
   assign lock_v    = act_value(lock_act, long_ff[ev_idx]);
   assign last_chan = idx_ff == CH_W'(CHANNELS - 1);

   assign blade_load = '{running: 1'b1, count: TIMER_WIDTH'(cfg.blade_ticks)};
   assign slong_load = '{running: 1'b1, count: TIMER_WIDTH'(cfg.short_long_ticks)};

   // With the result budget of this tick spent, an expiring short-to-long timer
   // is parked at zero and fires on a later tick.
   assign skip = ~cfg.long_short_mode & slong_ff[idx_ff].running
               & (slong_ff[idx_ff].count <= TIMER_WIDTH'(1))
               & (cnt_ff >= CNT_W'(MAX_RESULTS));

   // The single decrementer serves the blade timer and then the
   // short-to-long timer of each channel in turn.
   assign tu_cur = (state_ff == S_BLADE) ? blade_ff[idx_ff] : slong_ff[idx_ff];

   bpbc_timer_unit u_timer (
      .cur     (tu_cur),
      .nxt     (tu_nxt),
      .expired (tu_expired)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      long_in   = long_ff;
      short_in  = short_ff;
      blade_in  = blade_ff;
      slong_in  = slong_ff;
      res_cmd   = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_command)
                  CMD_TICK: begin
                     idx_in   = '0;
                     cnt_in   = '0;
                     state_in = S_BLADE;
                  end
                  CMD_PIN, CMD_LOCK: begin
                     state_in = S_EVENT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EVENT: begin
            if (res_ready) begin
               state_in = S_FLUSH;
               if (ev_ok) begin
                  case (cmd_ff)
                     CMD_PIN: begin
                        if (!pin_ff) begin
                           res_cmd.emit    = 1'b1;
                           res_cmd.channel = chan_ff;
                           res_cmd.value   = press_v;
                           if (!cfg.long_short_mode) begin
                              short_in[ev_idx] = press_v;
                              slong_in[ev_idx] = slong_load;
                              res_cmd.kind     = KIND_SHORT;
                           end else begin
                              long_in[ev_idx]  = press_v;
                              blade_in[ev_idx] = blade_load;
                              res_cmd.kind     = KIND_LONG;
                           end
                        end else begin
                           if (blade_ff[ev_idx].running) begin
                              short_in[ev_idx] = long_ff[ev_idx];
                              res_cmd.emit     = 1'b1;
                              res_cmd.kind     = KIND_SHORT;
                              res_cmd.channel  = chan_ff;
                              res_cmd.value    = long_ff[ev_idx];
                           end
                           blade_in[ev_idx].running = 1'b0;
                           slong_in[ev_idx].running = 1'b0;
                        end
                     end
                     CMD_LOCK: begin
                        if (lock_act != ACT_KEEP) begin
                           long_in[ev_idx] = lock_v;
                           res_cmd.emit    = 1'b1;
                           res_cmd.kind    = KIND_LONG;
                           res_cmd.channel = chan_ff;
                           res_cmd.value   = lock_v;
                        end
                     end
                     default: begin
                        state_in = S_FLUSH;
                     end
                  endcase
               end
            end
         end
         S_BLADE: begin
            blade_in[idx_ff] = tu_nxt;
            state_in         = S_SLONG;
         end
         S_SLONG: begin
            if (skip || !tu_expired || cfg.long_short_mode || res_ready) begin
               if (skip) begin
                  slong_in[idx_ff].count = '0;
               end else begin
                  slong_in[idx_ff] = tu_nxt;
                  if (tu_expired && !cfg.long_short_mode) begin
                     long_in[idx_ff]  = short_ff[idx_ff];
                     blade_in[idx_ff] = blade_load;
                     res_cmd.emit     = 1'b1;
                     res_cmd.kind     = KIND_LONG;
                     res_cmd.channel  = 3'(idx_ff);
                     res_cmd.value    = short_ff[idx_ff];
                     cnt_in           = cnt_ff + CNT_W'(1);
                  end
               end
               if (last_chan) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + CH_W'(1);
                  state_in = S_BLADE;
               end
            end
         end
         S_FLUSH: begin
            res_cmd.flush = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            long_ff[i]  <= 1'b0;
            short_ff[i] <= 1'b0;
            blade_ff[i] <= '0;
            slong_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         long_ff  <= long_in;
         short_ff <= short_in;
         blade_ff <= blade_in;
         slong_ff <= slong_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff  <= req_command;
         chan_ff <= req_channel;
         pin_ff  <= req_pin_level;
         lock_ff <= req_lock_state;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/blind_push_button_controller_core.sv -----
`default_nettype none

// Blind push-button controller for eight channels with a shared short-to-long
// and blade timer setting. One transaction is taken at a time: from the cycle
// after a pin, lock or tick command is accepted, req_stall is high until its
// last telegram has been handed to the output register. A pin or lock command
// passes through S_EVENT and S_FLUSH; a tick visits S_BLADE and S_SLONG for
// each channel and then S_FLUSH, as a single timer decrementer serves the blade
// timer and then the short-to-long timer of every channel in ascending order.
// Each transaction gives up to eight telegrams, the last marked by rsp_last;
// one with no telegram produces no result at all. The configuration port
// is always ready and must only be written while the block is idle.
module blind_push_button_controller_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [2:0]                      req_channel,
   input  logic                            req_pin_level,
   input  logic                            req_lock_state,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_telegram_kind,
   output logic [2:0]                      rsp_out_channel,
   output logic                            rsp_out_value,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpbc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bpbc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   res_cmd_type res_cmd;
   logic        res_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_MODE:       cfg_in.long_short_mode  = csr_data[0];
            CFG_PRESS:      cfg_in.press_action     = csr_data[1:0];
            CFG_BLADE:      cfg_in.blade_ticks      = csr_data[TICKS_W-1:0];
            CFG_SHORT_LONG: cfg_in.short_long_ticks = csr_data[TICKS_W-1:0];
            CFG_LOCK_ON:    cfg_in.lock_on_action   = csr_data[1:0];
            CFG_LOCK_OFF:   cfg_in.lock_off_action  = csr_data[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpbc_sequencer u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_channel    (req_channel),
      .req_pin_level  (req_pin_level),
      .req_lock_state (req_lock_state),
      .cfg            (cfg_ff),
      .res_ready      (res_ready),
      .res_cmd        (res_cmd)
   );

   bpbc_rsp_buffer u_rsp (
      .clock             (clock),
      .reset             (reset),
      .res_cmd           (res_cmd),
      .res_ready         (res_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_telegram_kind (rsp_telegram_kind),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/bpbc_checker.sv -----
`default_nettype none

module bpbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_telegram_kind,
   input logic [2:0] rsp_out_channel,
   input logic       rsp_out_value,
   input logic       rsp_last
);
   import bpbc_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_telegram_kind) && $stable(rsp_out_channel)
                                 && $stable(rsp_out_value) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // Any real command keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command != CMD_UNUSED |=> req_stall)
      else $error("block free straight after accepting a command");

   // While a telegram that is not the last one is shown, the transaction is
   // still in progress.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("block idle before the last telegram was produced");

endmodule

bind blind_push_button_controller_core bpbc_checker u_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpbc_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic PRESSED       = 1'b0;
   localparam logic RELEASED      = 1'b1;
   localparam logic LOCK_ENGAGED  = 1'b1;
   localparam logic LOCK_RELEASED = 1'b0;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER [6] = '{
      CFG_MODE, CFG_PRESS, CFG_BLADE, CFG_SHORT_LONG, CFG_LOCK_ON, CFG_LOCK_OFF
   };

   typedef struct packed {
      logic       kind;
      logic [2:0] channel;
      logic       value;
      logic       last;
   } telegram_type;

   // Tracks the per-channel blind state and holds the telegrams still owed by the block.
   class telegram_book;
      cfg_type                cfg;
      logic                   long_val  [CHANNELS];
      logic                   short_val [CHANNELS];
      logic [TIMER_WIDTH-1:0] blade_cnt [CHANNELS];
      logic                   blade_run [CHANNELS];
      logic [TIMER_WIDTH-1:0] slong_cnt [CHANNELS];
      logic                   slong_run [CHANNELS];
      telegram_type           pending [$];
      int                     failures;

      function new();
         cfg = CFG_RESET;
         failures = 0;
         for (int c = 0; c < CHANNELS; c++) begin
            long_val[c]  = 1'b0;
            short_val[c] = 1'b0;
            blade_cnt[c] = '0;
            blade_run[c] = 1'b0;
            slong_cnt[c] = '0;
            slong_run[c] = 1'b0;
         end
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CFG_MODE:       cfg.long_short_mode  = data[0];
            CFG_PRESS:      cfg.press_action     = data[1:0];
            CFG_BLADE:      cfg.blade_ticks      = data;
            CFG_SHORT_LONG: cfg.short_long_ticks = data;
            CFG_LOCK_ON:    cfg.lock_on_action   = data[1:0];
            CFG_LOCK_OFF:   cfg.lock_off_action  = data[1:0];
            default: ;
         endcase
      endfunction

      task report(string what);
         failures++;
         $display("MISMATCH at %0d ns: %s", $time, what);
      endtask

      // Works out the telegrams caused by one accepted transaction.
      task note_event(logic [1:0] cmd, logic [2:0] ch, logic pin, logic lock);
         telegram_type fresh [$];
         telegram_type t;
         logic         v;
         logic [1:0]   act;
         bit           expired;
         case (cmd)
            CMD_PIN: begin
               if (pin == PRESSED) begin
                  v = long_val[ch];
                  case (cfg.press_action)
                     ACT_ZERO:   v = 1'b0;
                     ACT_ONE:    v = 1'b1;
                     ACT_TOGGLE: v = ~v;
                     default: ;
                  endcase
                  if (!cfg.long_short_mode) begin
                     short_val[ch] = v;
                     fresh.push_back(telegram_type'{KIND_SHORT, ch, v, 1'b0});
                     slong_cnt[ch] = cfg.short_long_ticks;
                     slong_run[ch] = 1'b1;
                  end else begin
                     long_val[ch] = v;
                     fresh.push_back(telegram_type'{KIND_LONG, ch, v, 1'b0});
                     blade_cnt[ch] = cfg.blade_ticks;
                     blade_run[ch] = 1'b1;
                  end
               end else begin
                  if (blade_run[ch]) begin
                     short_val[ch] = long_val[ch];
                     fresh.push_back(telegram_type'{KIND_SHORT, ch, long_val[ch], 1'b0});
                  end
                  blade_run[ch] = 1'b0;
                  slong_run[ch] = 1'b0;
               end
            end
            CMD_TICK: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (blade_run[c]) begin
                     if (blade_cnt[c] != 0) blade_cnt[c]--;
                     if (blade_cnt[c] == 0) blade_run[c] = 1'b0;
                  end
                  // With the result budget spent, an expiring timer waits at zero.
                  if (!cfg.long_short_mode && slong_run[c] && slong_cnt[c] <= 1 &&
                      fresh.size() >= MAX_RESULTS) begin
                     slong_cnt[c] = '0;
                     continue;
                  end
                  expired = 1'b0;
                  if (slong_run[c]) begin
                     if (slong_cnt[c] != 0) slong_cnt[c]--;
                     if (slong_cnt[c] == 0) begin
                        slong_run[c] = 1'b0;
                        expired = 1'b1;
                     end
                  end
                  if (expired && !cfg.long_short_mode) begin
                     long_val[c] = short_val[c];
                     fresh.push_back(telegram_type'{KIND_LONG, 3'(c), short_val[c], 1'b0});
                     blade_cnt[c] = cfg.blade_ticks;
                     blade_run[c] = 1'b1;
                  end
               end
            end
            CMD_LOCK: begin
               act = lock ? cfg.lock_on_action : cfg.lock_off_action;
               if (act != ACT_KEEP) begin
                  case (act)
                     ACT_ZERO: v = 1'b0;
                     ACT_ONE:  v = 1'b1;
                     default:  v = ~long_val[ch];
                  endcase
                  long_val[ch] = v;
                  fresh.push_back(telegram_type'{KIND_LONG, ch, v, 1'b0});
               end
            end
            default: ;
         endcase
         foreach (fresh[i]) begin
            t = fresh[i];
            t.last = (i == fresh.size() - 1);
            pending.push_back(t);
         end
      endtask

      task check_telegram(telegram_type got);
         telegram_type want;
         if (pending.size() == 0) begin
            report($sformatf("telegram with nothing expected: kind %0d channel %0d value %0d last %0d",
                             got.kind, got.channel, got.value, got.last));
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.channel !== want.channel)
            report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
         if (got.value !== want.value)
            report($sformatf("value %0d, expected %0d on channel %0d",
                             got.value, want.value, want.channel));
         if (got.last !== want.last)
            report($sformatf("last %0d, expected %0d on channel %0d",
                             got.last, want.last, want.channel));
      endtask
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command    = CMD_UNUSED;
   logic [2:0]            req_channel    = '0;
   logic                  req_pin_level  = RELEASED;
   logic                  req_lock_state = LOCK_RELEASED;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_telegram_kind;
   logic [2:0]            rsp_out_channel;
   logic                  rsp_out_value;
   logic                  rsp_last;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_data       = '0;

   bit           calm = 1'b0;
   int           quiet_cycles = 0;
   telegram_book book = new();

   blind_push_button_controller_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_pin_level     (req_pin_level),
      .req_lock_state    (req_lock_state),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_telegram_kind (rsp_telegram_kind),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_telegram(telegram_type'{rsp_telegram_kind, rsp_out_channel,
                                            rsp_out_value, rsp_last});
   end

   // Back-pressure on the result side: short bursts, with the odd long quiet stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else if ($urandom_range(0, 4) == 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("blind_push_button_controller_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [2:0] ch, input logic pin,
                            input logic lock);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_channel    <= ch;
      req_pin_level  <= pin;
      req_lock_state <= lock;
      do @(posedge clock); while (req_stall);
      book.note_event(cmd, ch, pin, lock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Holds off new transactions until every owed telegram is in and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [1:0] press,
                            input logic [15:0] blade, input logic [15:0] slong,
                            input logic [1:0] lock_on, input logic [1:0] lock_off);
      logic [CSR_DATA_W-1:0] vals [6];
      vals = '{16'(mode), 16'(press), blade, slong, 16'(lock_on), 16'(lock_off)};
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         book.set_register(REG_ORDER[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 8)
         send_item(CMD_PIN, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      else if (pick < 15)
         send_item(CMD_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      else if (pick < 19)
         send_item(CMD_LOCK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      else
         send_item(CMD_UNUSED, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Short-long-short: press, expiry on the next tick, stop on release.
      configure(1'b0, ACT_TOGGLE, 16'd2, 16'd1, ACT_ONE, ACT_ZERO);
      send_item(CMD_PIN, 3'd0, PRESSED, LOCK_RELEASED);
      send_item(CMD_TICK, 3'd0, RELEASED, LOCK_RELEASED);
      send_item(CMD_PIN, 3'd0, RELEASED, LOCK_RELEASED);
      // Every channel pressed, so one tick yields the full eight telegrams.
      for (int c = 0; c < CHANNELS; c++) send_item(CMD_PIN, 3'(c), PRESSED, LOCK_ENGAGED);
      send_item(CMD_TICK, 3'd7, PRESSED, LOCK_ENGAGED);
      send_item(CMD_LOCK, 3'd7, RELEASED, LOCK_ENGAGED);
      send_item(CMD_LOCK, 3'd7, PRESSED, LOCK_RELEASED);
      send_item(CMD_UNUSED, 3'd5, PRESSED, LOCK_ENGAGED);
      send_item(CMD_TICK, 3'd0, RELEASED, LOCK_RELEASED);
      send_item(CMD_TICK, 3'd0, RELEASED, LOCK_RELEASED);
      // Blade timers have run out, so these releases say nothing.
      send_item(CMD_PIN, 3'd5, RELEASED, LOCK_RELEASED);
      send_item(CMD_PIN, 3'd3, RELEASED, LOCK_ENGAGED);

      // Long-short with zero-length timers and a lock action of none.
      configure(1'b1, ACT_ZERO, 16'd0, 16'd0, ACT_TOGGLE, ACT_KEEP);
      send_item(CMD_PIN, 3'd2, PRESSED, LOCK_RELEASED);
      send_item(CMD_PIN, 3'd2, RELEASED, LOCK_RELEASED);
      send_item(CMD_PIN, 3'd2, PRESSED, LOCK_RELEASED);
      send_item(CMD_TICK, 3'd2, PRESSED, LOCK_RELEASED);
      send_item(CMD_PIN, 3'd2, RELEASED, LOCK_RELEASED);
      send_item(CMD_LOCK, 3'd4, PRESSED, LOCK_RELEASED);
      send_item(CMD_LOCK, 3'd4, PRESSED, LOCK_ENGAGED);
      repeat (10) random_item();

      configure(1'b0, ACT_ONE, 16'hFFFF, 16'hFFFF, ACT_KEEP, ACT_TOGGLE);
      repeat (10) random_item();

      configure(1'b0, ACT_KEEP, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      repeat (15) random_item();
      drain();
      repeat (15) random_item();

      configure(1'($urandom_range(0, 1)), ACT_TOGGLE, 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      repeat (15) random_item();
      calm = 1'b1;
      repeat (10) random_item();

      drain();
      if (book.failures == 0)
         $display("blind_push_button_controller_core test passed");
      else
         $display("blind_push_button_controller_core test failed");
      $finish;
   end
endmodule
